@@ rtl/assert_macros.svh @@
// Assertion macros shared by the frame builder modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/crcfb_pkg.sv @@
// Package for the CRC-16 frame builder: constants, the job record and the
// byte-wise CRC function. Depends on nothing.
package crcfb_pkg;

    localparam logic [7:0]  FRAME_MARKER = 8'hA5;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] LEN_RESET    = 16'd64;
    localparam int          QUEUE_DEPTH  = 4;

    typedef struct packed {
        logic [7:0]  data;
        logic        header;
        logic        trailer;
        logic [15:0] length;
        logic [15:0] crc;
    } job_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/crcfb_front.sv @@
// Front end: holds the length register, counts payload bytes and runs the
// CRC, turning each accepted byte into a job. Depends on crcfb_pkg.
`include "assert_macros.svh"

module crcfb_front
    import crcfb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        q_full,
    output logic        q_push,
    output job_t        q_job
);

    logic [15:0] length_reg;
    logic [15:0] bytes_seen_reg, bytes_seen_next;
    logic [15:0] crc_reg, crc_next;
    logic [16:0] count;
    logic [16:0] limit;
    logic [15:0] crc_new;
    logic        frame_done;

    assign s_tready   = !q_full;
    assign q_push     = s_tvalid && s_tready;
    assign count      = {1'b0, bytes_seen_reg} + 17'd1;
    assign limit      = (length_reg == 16'd0) ? 17'h10000 : {1'b0, length_reg};
    assign frame_done = (count >= limit);
    assign crc_new    = crc16_byte(crc_reg, s_tdata);

    always_comb begin
        q_job.data    = s_tdata;
        q_job.header  = (bytes_seen_reg == 16'd0);
        q_job.trailer = frame_done;
        q_job.length  = length_reg;
        q_job.crc     = crc_new;
    end

    always_comb begin
        bytes_seen_next = bytes_seen_reg;
        crc_next        = crc_reg;
        if (q_push) begin
            if (frame_done) begin
                bytes_seen_next = 16'd0;
                crc_next        = CRC_INIT;
            end else begin
                bytes_seen_next = count[15:0];
                crc_next        = crc_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg     <= LEN_RESET;
            bytes_seen_reg <= 16'd0;
            crc_reg        <= CRC_INIT;
        end else begin
            if (cfg_wr_en) begin
                length_reg <= cfg_wr_data;
            end
            bytes_seen_reg <= bytes_seen_next;
            crc_reg        <= crc_next;
        end
    end

    // A byte that closes a frame leaves the counters ready for the next one.
    `ASSERT_NEXT(a_frame_restart, aclk, aresetn, q_push && frame_done, (bytes_seen_reg == 16'd0) && (crc_reg == CRC_INIT))
    // A header is only ever attached while the CRC is still at its start value.
    `ASSERT_SAME(a_header_crc_init, aclk, aresetn, q_push && q_job.header, crc_reg == CRC_INIT)

endmodule

@@ rtl/crcfb_queue.sv @@
// Short job queue between the front and back ends, held in flip-flops.
// Depends on crcfb_pkg for the job record.
`include "assert_macros.svh"

module crcfb_queue
    import crcfb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slots_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    `ASSERT_SAME(a_no_push_full, aclk, aresetn, push, !full)
    `ASSERT_SAME(a_no_pop_empty, aclk, aresetn, pop, head_valid)

endmodule

@@ rtl/crcfb_back.sv @@
// Back end: sends marker and length (header), payload and CRC (trailer) bytes
// per job on the registered output channel. Depends on crcfb_pkg.
`include "assert_macros.svh"

module crcfb_back
    import crcfb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       head_valid,
    input  job_t       head_job,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic [0:0] m_tuser
);

    typedef enum logic [2:0] {
        ST_MARK, ST_LEN_LO, ST_LEN_HI, ST_DATA, ST_CRC_LO, ST_CRC_HI
    } step_t;

    step_t      step_reg;
    logic       busy_reg;
    step_t      cur_step, nxt_step;
    logic       load;
    logic       job_last;
    logic [7:0] byte_sel;
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg;
    logic       run_last_reg;

    assign cur_step = busy_reg ? step_reg : (head_job.header ? ST_MARK : ST_DATA);
    assign load     = head_valid && (!m_tvalid_reg || m_tready);
    assign job_last = ((cur_step == ST_DATA) && !head_job.trailer) || (cur_step == ST_CRC_HI);
    assign pop      = load && job_last;

    always_comb begin
        byte_sel = head_job.data;
        nxt_step = ST_DATA;
        case (cur_step)
            ST_MARK: begin
                byte_sel = FRAME_MARKER;
                nxt_step = ST_LEN_LO;
            end
            ST_LEN_LO: begin
                byte_sel = head_job.length[7:0];
                nxt_step = ST_LEN_HI;
            end
            ST_LEN_HI: begin
                byte_sel = head_job.length[15:8];
                nxt_step = ST_DATA;
            end
            ST_DATA: begin
                byte_sel = head_job.data;
                nxt_step = ST_CRC_LO;
            end
            ST_CRC_LO: begin
                byte_sel = head_job.crc[7:0];
                nxt_step = ST_CRC_HI;
            end
            ST_CRC_HI: begin
                byte_sel = head_job.crc[15:8];
                nxt_step = ST_MARK;
            end
            default: begin
                byte_sel = head_job.data;
                nxt_step = ST_DATA;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= ST_MARK;
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_tvalid_reg <= 1'b1;
                busy_reg     <= !job_last;
                step_reg     <= nxt_step;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg  <= byte_sel;
            m_tlast_reg  <= (cur_step == ST_CRC_HI);
            run_last_reg <= job_last;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tlast    = m_tlast_reg;
    assign m_tuser[0] = run_last_reg;

    // The last byte of a frame is always the last byte of its input word.
    `ASSERT_SAME(a_end_is_run_last, aclk, aresetn, m_tvalid && m_tlast, m_tuser[0])
    // A job in progress keeps its queue entry until its last byte is loaded.
    `ASSERT_SAME(a_busy_has_job, aclk, aresetn, busy_reg, head_valid)

endmodule

@@ rtl/crc16_frame_builder.sv @@
// Top level of the CRC-16 frame builder: front end, job queue, back end.
// Depends on crcfb_pkg, crcfb_front, crcfb_queue and crcfb_back.
//
//  Port group     Direction  Payload
//  cfg_wr_*       in         payload_length[15:0]
//  s_axis-style   in         s_tdata = data_byte
//  m_axis-style   out        m_tdata = out_byte, m_tlast = frame_end, m_tuser = run_last
//
// The front end takes one payload word a cycle while the queue has room.
// The back end sends one byte a cycle from its output register while a job
// is queued and m_tready is high: four bytes for a word that opens a frame,
// three for one that closes it, six for one that opens and closes it and one
// for any other. A word's first byte passes through a queue slot and the output
// register before it is valid. Reset is synchronous and active low and clears
// the counters, queue and output valid. Each side stalls on its own through the queue.

module crc16_frame_builder
    import crcfb_pkg::*;
#(
    parameter int FIFO_DEPTH = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,  // payload_length
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,      // out_byte
    output logic        m_tlast,      // frame_end
    output logic [0:0]  m_tuser       // run_last
);

    logic q_full;
    logic q_push;
    job_t q_job;
    logic q_pop;
    logic q_valid;
    job_t q_head;

    crcfb_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (q_job)
    );

    crcfb_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (q_head)
    );

    crcfb_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_valid),
        .head_job   (q_head),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule
